@@ design/ust_pkg.sv @@
// Shared types and constants for the UV-sphere tessellator.
// No dependencies; imported by ust_sine, uv_sphere_tessellator and the testbench.
`default_nettype none
package ust_pkg;

	typedef longint unsigned u64_t;

	localparam int DEF_MAX_STACKS      = 64;
	localparam int DEF_MAX_SLICES      = 128;
	localparam int DEF_SINE_TABLE_BITS = 10;
	localparam int DIV_STAGES          = 4;

	localparam u64_t HALFPI_Q30 = 64'd1686629713;
	localparam u64_t ONE_Q30    = 64'd1 << 30;
	localparam int unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};

	typedef enum logic [1:0] {
		CFG_RADIUS = 2'd0,
		CFG_STACKS = 2'd1,
		CFG_SLICES = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic        vtx;
		logic        pole;
		logic        top;
		logic        tri_ok;
		logic        bad;
		logic [12:0] ca;
		logic [12:0] cb;
		logic [12:0] cc;
		logic [15:0] radius;
	} side_t;

endpackage
`default_nettype wire

@@ design/ust_divider.sv @@
// Pipelined restoring divider; each stage computes BPS quotient bits and registers them.
// Depends on nothing; instantiated by uv_sphere_tessellator.
`default_nettype none
module ust_divider #(
	parameter int NW     = 24,
	parameter int DW     = 8,
	parameter int STAGES = 4
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo
);
	localparam int BPS = (NW + STAGES - 1) / STAGES;
	localparam int QB  = BPS * STAGES;

	logic [DW-1:0] rem_s [STAGES+1];
	logic [QB-1:0] num_s [STAGES+1];
	logic [DW-1:0] den_s [STAGES+1];

	assign rem_s[0] = '0;
	assign num_s[0] = QB'(num);
	assign den_s[0] = den;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [DW-1:0] rem_n;
		logic [QB-1:0] num_n;

		always_comb begin
			logic [DW:0] t;
			rem_n = rem_s[g];
			num_n = num_s[g];
			t     = '0;
			for (int k = 0; k < BPS; k++) begin
				t     = {rem_n, num_n[QB-1]};
				num_n = {num_n[QB-2:0], 1'b0};
				if (t >= {1'b0, den_s[g]}) begin
					rem_n    = DW'(t - {1'b0, den_s[g]});
					num_n[0] = 1'b1;
				end else begin
					rem_n = t[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_n;
			num_s[g+1] <= num_n;
			den_s[g+1] <= den_s[g];
		end
	end

	assign quo = num_s[STAGES][NW-1:0];

endmodule
`default_nettype wire

@@ design/ust_sine.sv @@
// Quarter-wave sine lookup with registered Q1.14 output.
// Depends on ust_pkg for the series constants used to build the table.
`default_nettype none
module ust_sine #(
	parameter int SINE_TABLE_BITS = ust_pkg::DEF_SINE_TABLE_BITS
) (
	input  wire logic                       clk,
	input  wire logic [SINE_TABLE_BITS-1:0] phase,
	output logic signed [15:0]              sine
);
	import ust_pkg::*;

	localparam int QN = 1 << (SINE_TABLE_BITS - 2);
	localparam int IW = SINE_TABLE_BITS - 1;

	typedef logic [14:0] rom_t [0:QN];

	function automatic u64_t udiv_slow(u64_t n, u64_t d);
		u64_t q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		u64_t x, x2, t, s;
		for (int r = 0; r <= QN; r++) begin
			x  = (u64_t'(r) * HALFPI_Q30) >> (SINE_TABLE_BITS - 2);
			x2 = (x * x) >> 30;
			t  = ONE_Q30;
			for (int k = 0; k < 5; k++)
				t = ONE_Q30 - udiv_slow((x2 * t) >> 30, u64_t'(TAYLOR_DIV[k]));
			s = (x * t) >> 30;
			s = (s + 64'd32768) >> 16;
			if (s > 64'd16384)
				s = 64'd16384;
			rom[r] = 15'(s);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [1:0]    quad;
	logic [IW-1:0] idx;
	logic [14:0]   mag;

	assign quad = phase[SINE_TABLE_BITS-1 -: 2];

	always_comb begin
		idx = {1'b0, phase[SINE_TABLE_BITS-3:0]};
		if (quad[0])
			idx = IW'(QN) - idx;
	end

	assign mag = SINE_ROM[idx];

	always_ff @(posedge clk) begin
		sine <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule
`default_nettype wire

@@ design/uv_sphere_tessellator.sv @@
// Top level of the UV-sphere tessellator: config registers, request stage,
// triangle indexing, normal and position stages. Uses ust_pkg, ust_divider, ust_sine.
//
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+---------------------------
// config    | cfg_we, cfg_idx, cfg_wdata                | write when cfg_we high
// request   | kind, row, col, half                      | start high, busy low
// result    | pos_*, nrm_*, tex_*, corner_*, bad_request| done high for one cycle
//
// One request enters per cycle; busy is always low.
// Each result passes through the request stage, the pipelined phase dividers (four
// stages), and the sine, normal and output stages.
// Reset restores radius 128, 16 stacks and 32 slices and empties the pipeline.
// The result side has no stall; the pipeline advances every cycle.
`default_nettype none
module uv_sphere_tessellator #(
	parameter int MAX_STACKS      = ust_pkg::DEF_MAX_STACKS,
	parameter int MAX_SLICES      = ust_pkg::DEF_MAX_SLICES,
	parameter int SINE_TABLE_BITS = ust_pkg::DEF_SINE_TABLE_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire ust_pkg::cfg_idx_t  cfg_idx,
	input  wire logic [15:0]        cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [6:0]         row,
	input  wire logic [7:0]         col,
	input  wire logic               half,
	output logic                    done,
	output logic signed [16:0]      pos_x,
	output logic signed [16:0]      pos_y,
	output logic signed [16:0]      pos_z,
	output logic signed [15:0]      nrm_x,
	output logic signed [15:0]      nrm_y,
	output logic signed [15:0]      nrm_z,
	output logic [15:0]             tex_u,
	output logic [15:0]             tex_v,
	output logic [12:0]             corner_a,
	output logic [12:0]             corner_b,
	output logic [12:0]             corner_c,
	output logic                    bad_request
);
	import ust_pkg::*;

	localparam int B       = SINE_TABLE_BITS;
	localparam int QN      = 1 << (B - 2);
	localparam int LATENCY = DIV_STAGES + 4;

	function automatic logic signed [33:0] rnd14(input logic signed [33:0] p);
		logic [33:0] mag;
		mag = p[33] ? 34'(-p) : p;
		mag = (mag + 34'd8192) >> 14;
		return p[33] ? -$signed(mag) : $signed(mag);
	endfunction

	logic [15:0] radius_q;
	logic [6:0]  stacks_q;
	logic [7:0]  slices_q;
	logic [6:0]  stacks_eff;
	logic [7:0]  slices_eff;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd128;
			stacks_q <= 7'd16;
			slices_q <= 8'd32;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_RADIUS: radius_q <= cfg_wdata;
				CFG_STACKS: stacks_q <= cfg_wdata[6:0];
				CFG_SLICES: slices_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (stacks_q < 7'd2)
			stacks_eff = 7'd2;
		else if (int'(stacks_q) > MAX_STACKS)
			stacks_eff = 7'(MAX_STACKS);
		else
			stacks_eff = stacks_q;
		if (slices_q < 8'd3)
			slices_eff = 8'd3;
		else if (int'(slices_q) > MAX_SLICES)
			slices_eff = 8'(MAX_SLICES);
		else
			slices_eff = slices_q;
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// request stage
	logic        vld_s1, kind_s1, half_s1;
	logic [6:0]  row_s1, stacks_s1;
	logic [7:0]  col_s1, slices_s1;
	logic [15:0] radius_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			row_s1    <= row;
			col_s1    <= col;
			half_s1   <= half;
			stacks_s1 <= stacks_eff;
			slices_s1 <= slices_eff;
			radius_s1 <= radius_q;
		end
	end

	logic [B+7:0]  num_t;
	logic [B+9:0]  num_p;
	logic [24:0]   num_u;
	logic [23:0]   num_v;
	logic [7:0]    den_st;
	logic [8:0]    den_sl;
	side_t         side_s1;

	assign num_t  = (B+8)'({row_s1, {B{1'b0}}}) + (B+8)'(stacks_s1);
	assign num_p  = (B+10)'({col_s1, {(B+1){1'b0}}}) + (B+10)'(slices_s1);
	assign num_u  = {1'b0, col_s1, 16'd0} + 25'(slices_s1);
	assign num_v  = {1'b0, row_s1, 16'd0} + 24'(stacks_s1);
	assign den_st = {stacks_s1, 1'b0};
	assign den_sl = {slices_s1, 1'b0};

	always_comb begin
		logic [15:0] rv, bottom, last, curr, c16, a, b, c;
		logic        vbad, tbad;
		rv     = 16'(slices_s1) + 16'd1;
		bottom = 16'd1 + 16'(stacks_s1 - 7'd1) * rv;
		last   = 16'd1 + 16'(stacks_s1 - 7'd2) * rv;
		curr   = 16'd1 + 16'(row_s1 - 7'd1) * rv;
		c16    = 16'(col_s1);
		if (row_s1 == 7'd0) begin
			a = 16'd0;
			b = c16 + 16'd2;
			c = c16 + 16'd1;
		end else if (row_s1 == stacks_s1 - 7'd1) begin
			a = bottom;
			b = last + c16;
			c = last + c16 + 16'd1;
		end else if (!half_s1) begin
			a = curr + c16;
			b = curr + rv + c16;
			c = curr + c16 + 16'd1;
		end else begin
			a = curr + c16 + 16'd1;
			b = curr + rv + c16;
			c = curr + rv + c16 + 16'd1;
		end
		vbad = (row_s1 > stacks_s1) || (col_s1 > slices_s1);
		tbad = (row_s1 >= stacks_s1) || (col_s1 >= slices_s1);
		side_s1.vtx    = !kind_s1 && !vbad;
		side_s1.pole   = (row_s1 == 7'd0) || (row_s1 == stacks_s1);
		side_s1.top    = (row_s1 == 7'd0);
		side_s1.tri_ok = kind_s1 && !tbad;
		side_s1.bad    = kind_s1 ? tbad : vbad;
		side_s1.ca     = a[12:0];
		side_s1.cb     = b[12:0];
		side_s1.cc     = c[12:0];
		side_s1.radius = radius_s1;
	end

	// phase and texture dividers
	logic [B+7:0] quo_t;
	logic [B+9:0] quo_p;
	logic [24:0]  quo_u;
	logic [23:0]  quo_v;

	ust_divider #(.NW(B+8),  .DW(8), .STAGES(DIV_STAGES)) u_div_t (
		.clk(clk), .num(num_t), .den(den_st), .quo(quo_t));
	ust_divider #(.NW(B+10), .DW(9), .STAGES(DIV_STAGES)) u_div_p (
		.clk(clk), .num(num_p), .den(den_sl), .quo(quo_p));
	ust_divider #(.NW(25),   .DW(9), .STAGES(DIV_STAGES)) u_div_u (
		.clk(clk), .num(num_u), .den(den_sl), .quo(quo_u));
	ust_divider #(.NW(24),   .DW(8), .STAGES(DIV_STAGES)) u_div_v (
		.clk(clk), .num(num_v), .den(den_st), .quo(quo_v));

	logic  vld_sd  [DIV_STAGES];
	side_t side_sd [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				vld_sd[k] <= 1'b0;
		end else begin
			vld_sd[0] <= vld_s1;
			for (int k = 1; k < DIV_STAGES; k++)
				vld_sd[k] <= vld_sd[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_sd[0] <= side_s1;
		for (int k = 1; k < DIV_STAGES; k++)
			side_sd[k] <= side_sd[k-1];
	end

	// sine lookup stage
	logic [B-1:0]        ph_t, ph_tc, ph_p, ph_pc;
	logic signed [15:0]  st_s6, ct_s6, sp_s6, cp_s6;
	logic                vld_s6;
	side_t               side_s6;
	logic [15:0]         u_s6, v_s6;

	assign ph_t  = quo_t[B-1:0];
	assign ph_tc = quo_t[B-1:0] + B'(QN);
	assign ph_p  = quo_p[B-1:0];
	assign ph_pc = quo_p[B-1:0] + B'(QN);

	ust_sine #(.SINE_TABLE_BITS(B)) u_sin_t  (.clk(clk), .phase(ph_t),  .sine(st_s6));
	ust_sine #(.SINE_TABLE_BITS(B)) u_cos_t  (.clk(clk), .phase(ph_tc), .sine(ct_s6));
	ust_sine #(.SINE_TABLE_BITS(B)) u_sin_p  (.clk(clk), .phase(ph_p),  .sine(sp_s6));
	ust_sine #(.SINE_TABLE_BITS(B)) u_cos_p  (.clk(clk), .phase(ph_pc), .sine(cp_s6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= vld_sd[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_sd[DIV_STAGES-1];
		u_s6    <= quo_u[15:0];
		v_s6    <= quo_v[15:0];
	end

	// normal stage
	logic               vld_s7;
	side_t              side_s7;
	logic signed [15:0] nx_s7, ny_s7, nz_s7;
	logic [15:0]        u_s7, v_s7;
	logic signed [33:0] pnx, pnz;

	assign pnx = 34'(st_s6) * 34'(cp_s6);
	assign pnz = 34'(st_s6) * 34'(sp_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else
			vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		if (!side_s6.vtx) begin
			nx_s7 <= '0;
			ny_s7 <= '0;
			nz_s7 <= '0;
			u_s7  <= '0;
			v_s7  <= '0;
		end else if (side_s6.pole) begin
			nx_s7 <= '0;
			ny_s7 <= side_s6.top ? 16'sd16384 : -16'sd16384;
			nz_s7 <= '0;
			u_s7  <= '0;
			v_s7  <= v_s6;
		end else begin
			nx_s7 <= 16'(rnd14(pnx));
			ny_s7 <= ct_s6;
			nz_s7 <= 16'(rnd14(pnz));
			u_s7  <= u_s6;
			v_s7  <= v_s6;
		end
	end

	// position and output stage
	logic signed [33:0] rad34, ppx, ppy, ppz;
	logic               done_s8, bad_s8;
	logic signed [16:0] px_s8, py_s8, pz_s8;
	logic signed [15:0] nx_s8, ny_s8, nz_s8;
	logic [15:0]        u_s8, v_s8;
	logic [12:0]        ca_s8, cb_s8, cc_s8;

	assign rad34 = $signed({18'd0, side_s7.radius});
	assign ppx   = 34'(nx_s7) * rad34;
	assign ppy   = 34'(ny_s7) * rad34;
	assign ppz   = 34'(nz_s7) * rad34;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_s8 <= 1'b0;
		else
			done_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		px_s8  <= 17'(rnd14(ppx));
		py_s8  <= 17'(rnd14(ppy));
		pz_s8  <= 17'(rnd14(ppz));
		nx_s8  <= nx_s7;
		ny_s8  <= ny_s7;
		nz_s8  <= nz_s7;
		u_s8   <= u_s7;
		v_s8   <= v_s7;
		bad_s8 <= side_s7.bad;
		ca_s8  <= side_s7.tri_ok ? side_s7.ca : 13'd0;
		cb_s8  <= side_s7.tri_ok ? side_s7.cb : 13'd0;
		cc_s8  <= side_s7.tri_ok ? side_s7.cc : 13'd0;
	end

	assign done        = done_s8;
	assign pos_x       = px_s8;
	assign pos_y       = py_s8;
	assign pos_z       = pz_s8;
	assign nrm_x       = nx_s8;
	assign nrm_y       = ny_s8;
	assign nrm_z       = nz_s8;
	assign tex_u       = u_s8;
	assign tex_v       = v_s8;
	assign corner_a    = ca_s8;
	assign corner_b    = cb_s8;
	assign corner_c    = cc_s8;
	assign bad_request = bad_s8;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result strobe missing after request");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_request |-> pos_x == 17'sd0 && nrm_y == 16'sd0 &&
			corner_a == 13'd0 && tex_v == 16'd0)
		else $error("bad request carries nonzero payload");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> tex_u <= 16'd32768 && tex_v <= 16'd32768)
		else $error("texture coordinate out of range");

endmodule
`default_nettype wire

@@ tb/uv_sphere_tessellator_tb.sv @@
// Self-checking testbench for uv_sphere_tessellator: predicts every vertex and
// triangle transaction in SystemVerilog and compares each strobed result in order.
// Depends on ust_pkg and the uv_sphere_tessellator RTL.
`timescale 1ns / 1ps
module uv_sphere_tessellator_tb;
	import ust_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic KIND_VTX = 1'b0;
	localparam logic KIND_TRI = 1'b1;

	typedef struct {
		logic signed [16:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
		logic [15:0]        u, v;
		logic [12:0]        a, b, c;
		logic               bad;
	} sphere_res_t;

	logic clk, arst_n, cfg_we, start, busy, kind, half, done;
	cfg_idx_t cfg_idx;
	logic [15:0] cfg_wdata;
	logic [6:0] row;
	logic [7:0] col;
	logic signed [16:0] pos_x, pos_y, pos_z;
	logic signed [15:0] nrm_x, nrm_y, nrm_z;
	logic [15:0] tex_u, tex_v;
	logic [12:0] corner_a, corner_b, corner_c;
	logic bad_request;

	sphere_res_t expected_q[$];
	int errors = 0;
	bit no_idle = 0;
	longint unsigned sh_radius, sh_stacks, sh_slices;

	uv_sphere_tessellator dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint sine_mag(longint unsigned r);
		longint unsigned x, x2, t, s;
		x = (r * HALFPI_Q30) >> 8;
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		for (int k = 0; k < 5; k++)
			t = ONE_Q30 - ((x2 * t) >> 30) / TAYLOR_DIV[k];
		s = (x * t) >> 30;
		s = (s + (64'd1 << 15)) >> 16;
		if (s > 16384) s = 16384;
		return longint'(s);
	endfunction

	function automatic longint sine_at(longint unsigned p);
		longint unsigned quad, r;
		longint m;
		p = p & 1023;
		quad = p >> 8;
		r = p & 255;
		if (quad[0]) r = 256 - r;
		m = sine_mag(r);
		return (quad >= 2) ? -m : m;
	endfunction

	function automatic longint mul_rnd(longint a, longint b);
		longint prod, mag;
		prod = a * b;
		mag = (prod < 0) ? -prod : prod;
		mag = (mag + 8192) >>> 14;
		return (prod < 0) ? -mag : mag;
	endfunction

	function automatic sphere_res_t predict_sphere(logic k, logic [6:0] r, logic [7:0] c,
			logic h);
		sphere_res_t e;
		longint unsigned stacks, slices, rv, bottom, tp, pp, last, curr, ri, ci;
		longint st, ct, sp, cp, nx, ny, nz, rad;
		e = '{default: '0};
		stacks = sh_stacks < 2 ? 2 : (sh_stacks > 64 ? 64 : sh_stacks);
		slices = sh_slices < 3 ? 3 : (sh_slices > 128 ? 128 : sh_slices);
		rv = slices + 1;
		bottom = 1 + (stacks - 1) * rv;
		rad = longint'(sh_radius);
		ri = 64'(r);
		ci = 64'(c);
		if (k == KIND_VTX) begin
			if (ri > stacks || ci > slices) begin
				e.bad = 1'b1;
			end else if (ri == 0 || ri == stacks) begin
				e.py = 17'((ri == 0) ? rad : -rad);
				e.ny = 16'((ri == 0) ? 16384 : -16384);
				e.v = 16'((ri == 0) ? 0 : 32768);
			end else begin
				tp = (ri * 1024 + stacks) / (2 * stacks);
				pp = (2 * ci * 1024 + slices) / (2 * slices);
				st = sine_at(tp);
				ct = sine_at(tp + 256);
				sp = sine_at(pp);
				cp = sine_at(pp + 256);
				nx = mul_rnd(st, cp);
				ny = ct;
				nz = mul_rnd(st, sp);
				e.nx = 16'(nx); e.ny = 16'(ny); e.nz = 16'(nz);
				e.px = 17'(mul_rnd(nx, rad));
				e.py = 17'(mul_rnd(ny, rad));
				e.pz = 17'(mul_rnd(nz, rad));
				e.u = 16'((ci * 65536 + slices) / (2 * slices));
				e.v = 16'((ri * 65536 + stacks) / (2 * stacks));
			end
		end else if (ri >= stacks || ci >= slices) begin
			e.bad = 1'b1;
		end else if (ri == 0) begin
			e.a = 13'd0; e.b = 13'(2 + ci); e.c = 13'(1 + ci);
		end else if (ri == stacks - 1) begin
			last = 1 + (stacks - 2) * rv;
			e.a = 13'(bottom); e.b = 13'(last + ci); e.c = 13'(last + ci + 1);
		end else begin
			curr = 1 + (ri - 1) * rv;
			if (!h) begin
				e.a = 13'(curr + ci); e.b = 13'(curr + rv + ci); e.c = 13'(curr + ci + 1);
			end else begin
				e.a = 13'(curr + ci + 1); e.b = 13'(curr + rv + ci);
				e.c = 13'(curr + rv + ci + 1);
			end
		end
		return e;
	endfunction

	task automatic report(string what, longint got, longint exp);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
	endtask

	always @(posedge clk) begin
		sphere_res_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report("unexpected transaction", 1, 0);
			end else begin
				e = expected_q.pop_front();
				if (pos_x !== e.px) report("pos_x", pos_x, e.px);
				if (pos_y !== e.py) report("pos_y", pos_y, e.py);
				if (pos_z !== e.pz) report("pos_z", pos_z, e.pz);
				if (nrm_x !== e.nx) report("nrm_x", nrm_x, e.nx);
				if (nrm_y !== e.ny) report("nrm_y", nrm_y, e.ny);
				if (nrm_z !== e.nz) report("nrm_z", nrm_z, e.nz);
				if (tex_u !== e.u) report("tex_u", tex_u, e.u);
				if (tex_v !== e.v) report("tex_v", tex_v, e.v);
				if (corner_a !== e.a) report("corner_a", corner_a, e.a);
				if (corner_b !== e.b) report("corner_b", corner_b, e.b);
				if (corner_c !== e.c) report("corner_c", corner_c, e.c);
				if (bad_request !== e.bad) report("bad_request", bad_request, e.bad);
			end
		end
	end

	task automatic send_request(logic k, logic [6:0] r, logic [7:0] c, logic h);
		int gap;
		logic b;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		kind <= k;
		row <= r;
		col <= c;
		half <= h;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		expected_q.insert(expected_q.size(), predict_sphere(k, r, c, h));
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_idx <= cfg_idx_t'(idx);
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_RADIUS: sh_radius = val;
			CFG_STACKS: sh_stacks = val & 16'h7F;
			CFG_SLICES: sh_slices = val & 16'hFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_sphere(logic [15:0] rad, logic [15:0] stk, logic [15:0] slc);
		drain();
		write_reg(CFG_RADIUS, rad);
		write_reg(CFG_STACKS, stk);
		write_reg(CFG_SLICES, slc);
	endtask

	task automatic random_requests(int n);
		int stacks, slices;
		stacks = int'(sh_stacks < 2 ? 2 : (sh_stacks > 64 ? 64 : sh_stacks));
		slices = int'(sh_slices < 3 ? 3 : (sh_slices > 128 ? 128 : sh_slices));
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				send_request(1'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
			else
				send_request(1'($urandom), 7'($urandom_range(0, stacks)),
					8'($urandom_range(0, slices)), 1'($urandom));
		end
		no_idle = 0;
	endtask

	task automatic test_default_grid();
		send_request(KIND_VTX, 0, 0, 0);
		send_request(KIND_VTX, 0, 32, 1);
		send_request(KIND_VTX, 16, 7, 0);
		send_request(KIND_VTX, 1, 0, 0);
		send_request(KIND_VTX, 8, 8, 0);
		send_request(KIND_VTX, 15, 32, 0);
		send_request(KIND_VTX, 17, 0, 0);
		send_request(KIND_VTX, 3, 33, 0);
		send_request(KIND_VTX, 7'h7F, 8'hFF, 1);
		send_request(KIND_TRI, 0, 0, 0);
		send_request(KIND_TRI, 0, 31, 1);
		send_request(KIND_TRI, 15, 0, 1);
		send_request(KIND_TRI, 15, 31, 0);
		send_request(KIND_TRI, 5, 4, 0);
		send_request(KIND_TRI, 5, 4, 1);
		send_request(KIND_TRI, 16, 0, 0);
		send_request(KIND_TRI, 3, 32, 0);
		send_request(KIND_TRI, 7'h7F, 8'hFF, 1);
		random_requests(100);
	endtask

	task automatic test_clamped_counts();
		set_sphere(16'h0000, 16'h0000, 16'h0000);
		write_reg(CFG_UNUSED, 16'h00FF);
		random_requests(150);
		set_sphere(16'h0001, 16'h0001, 16'h0002);
		random_requests(150);
		set_sphere(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_requests(200);
	endtask

	task automatic test_full_grid();
		set_sphere(16'hFFFF, 16'd64, 16'd128);
		send_request(KIND_VTX, 64, 128, 0);
		send_request(KIND_TRI, 63, 127, 1);
		send_request(KIND_TRI, 62, 127, 1);
		random_requests(200);
		drain();
		random_requests(100);
	endtask

	task automatic test_random_spheres();
		for (int p = 0; p < 6; p++) begin
			set_sphere(16'($urandom), 16'($urandom_range(0, 70)),
				16'($urandom_range(0, 140)));
			random_requests(120);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = CFG_RADIUS;
		cfg_wdata = 0;
		start = 0;
		kind = 0;
		row = 0;
		col = 0;
		half = 0;
		sh_radius = 128;
		sh_stacks = 16;
		sh_slices = 32;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_default_grid();
		test_clamped_counts();
		test_full_grid();
		test_random_spheres();
		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
